// File: sv/append_only_key_value_table_defines.svh
// Assertion macros used by the table's controller RTL (aokvt_ctrl).
`ifndef APPEND_ONLY_KEY_VALUE_TABLE_DEFINES_SVH
`define APPEND_ONLY_KEY_VALUE_TABLE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define AOKVT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define AOKVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/aokvt_pkg.sv
// Package with field widths, opcodes, status codes and defaults of the table.
package aokvt_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_BITS    = 32;
    localparam int DEF_VALUE_BITS  = 32;

    localparam int OPCODE_W = 2;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;

    typedef logic [OPCODE_W-1:0] t_opcode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_opcode OP_APPEND = 2'd0;
    localparam t_opcode OP_FIND   = 2'd1;
    localparam t_opcode OP_READ   = 2'd2;

    localparam t_status STS_OK        = 2'd0;
    localparam t_status STS_NOT_FOUND = 2'd1;
    localparam t_status STS_FULL      = 2'd2;
    localparam t_status STS_UNWRITTEN = 2'd3;

endpackage

// File: sv/aokvt_ram.sv
// Single write port, single registered read port memory.
module aokvt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/aokvt_ctrl.sv
// Sequencer with the shared masked key comparator and the result register.
`include "append_only_key_value_table_defines.svh"

module aokvt_ctrl
    import aokvt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = DEF_KEY_BITS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_opcode               i_opcode,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [INDEX_W-1:0]    i_entry_index,
    input  logic [KEY_BITS-1:0]   i_mask,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [AW-1:0]         o_key_raddr,
    output logic [AW-1:0]         o_val_raddr,
    input  logic [KEY_BITS-1:0]   i_key_rdata,
    input  logic [VALUE_BITS-1:0] i_val_rdata,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output t_status               o_status,
    output logic [AW-1:0]         o_index,
    output logic [VALUE_BITS-1:0] o_value
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_RDWAIT = 2'd2;
    localparam logic [1:0] ST_FIN    = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_scan, n_scan;
    logic [KEY_BITS-1:0]   r_key, n_key;
    t_status               r_res_status, n_res_status;
    logic [AW-1:0]         r_res_index, n_res_index;
    logic [VALUE_BITS-1:0] r_res_value, n_res_value;
    logic                  r_out_valid, n_out_valid;
    t_status               r_status, n_status;
    logic [AW-1:0]         r_index, n_index;
    logic [VALUE_BITS-1:0] r_value, n_value;

    logic [IW-1:0] idx_w;
    logic [IW-1:0] cnt_w;
    logic          idx_ok;
    logic          full;
    logic          match;
    logic [CW-1:0] scan_nxt;
    logic          wr_en;

    assign idx_w    = IW'(i_entry_index);
    assign cnt_w    = IW'(r_count);
    assign idx_ok   = idx_w < cnt_w;
    assign full     = r_count == CW'(TABLE_DEPTH);
    assign match    = ((i_key_rdata ^ r_key) & i_mask) == '0;
    assign scan_nxt = CW'(r_scan) + CW'(1);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_scan       = r_scan;
        n_key        = r_key;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_res_value  = r_res_value;
        n_out_valid  = r_out_valid;
        n_status     = r_status;
        n_index      = r_index;
        n_value      = r_value;
        wr_en        = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_key        = i_key;
                    n_res_status = STS_OK;
                    n_res_index  = '0;
                    n_res_value  = '0;
                    n_state      = ST_FIN;
                    case (i_opcode)
                        OP_APPEND: begin
                            if (full) begin
                                n_res_status = STS_FULL;
                            end else begin
                                wr_en       = 1'b1;
                                n_res_index = r_count[AW-1:0];
                                n_count     = r_count + CW'(1);
                            end
                        end
                        OP_FIND: begin
                            if (r_count == '0) begin
                                n_res_status = STS_NOT_FOUND;
                            end else begin
                                n_scan  = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            if (idx_ok) begin
                                n_state = ST_RDWAIT;
                            end else begin
                                n_res_status = STS_UNWRITTEN;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (match) begin
                    n_res_index = r_scan;
                    n_state     = ST_FIN;
                end else if (scan_nxt == r_count) begin
                    n_res_status = STS_NOT_FOUND;
                    n_state      = ST_FIN;
                end else begin
                    n_scan = scan_nxt[AW-1:0];
                end
            end
            ST_RDWAIT: begin
                n_res_value = i_val_rdata;
                n_state     = ST_FIN;
            end
            default: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res_status;
                    n_index     = r_res_index;
                    n_value     = r_res_value;
                    n_state     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_scan       <= n_scan;
        r_key        <= n_key;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_res_value  <= n_res_value;
        r_status     <= n_status;
        r_index      <= n_index;
        r_value      <= n_value;
    end

    assign o_stall     = r_state != ST_IDLE;
    assign o_wr_en     = wr_en;
    assign o_wr_addr   = r_count[AW-1:0];
    assign o_key_raddr = (r_state == ST_SCAN) ? scan_nxt[AW-1:0] : '0;
    assign o_val_raddr = idx_w[AW-1:0];
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_index     = r_index;
    assign o_value     = r_value;

    `AOKVT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(TABLE_DEPTH), "entry count past depth")
    `AOKVT_ASSERT_NEXT(a_append_grows, (r_state == ST_IDLE) && i_valid && (i_opcode == OP_APPEND) && !full, r_count == CW'($past(r_count) + CW'(1)), "append did not grow count")
    `AOKVT_ASSERT_NOW(a_scan_in_range, r_state == ST_SCAN, CW'(r_scan) < r_count, "scan beyond stored entries")
    `AOKVT_ASSERT_NEXT(a_count_stable_busy, r_state != ST_IDLE, r_count == $past(r_count), "count changed while busy")

endmodule

// File: sv/append_only_key_value_table.sv
// Top level of the append-only key/value table with linear find.
//
// Input channel i_valid/o_stall carries one item: opcode, key, value, entry_index.
// Output channel o_valid/i_stall returns one item per request: status,
// found_index, read_value. An item moves at an edge with valid high and stall low.
// Only one request is in work at a time; o_stall is high from acceptance until
// its result has been loaded into the output register.
// From acceptance an append, or a request that fails at once, goes to the finish
// state; a read waits in a state for the value memory; a find scans stored keys
// from index 0 to a hit or the last entry. The finish state loads the output
// register and raises o_valid, and the block then idles for the next item. The
// find loop sets the worst case: it compares one stored key per cycle through the key memory's read port.
// When the receiver stalls, the result holds in the output register and a
// finished request waits for it before the next item is taken.
// i_cfg_we writes the key compare mask; write it only while the block is idle.
// Reset (synchronous, active low) empties the table and sets the mask to all
// ones; the key and value memories are not cleared.
module append_only_key_value_table
    import aokvt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = DEF_KEY_BITS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [KEY_W-1:0]   i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_opcode            i_opcode,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [INDEX_W-1:0] i_entry_index,
    output logic               o_valid,
    input  logic               i_stall,
    output t_status            o_status,
    output logic [INDEX_W-1:0] o_found_index,
    output logic [VALUE_W-1:0] o_read_value
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int KW = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;
    localparam int VW = (VALUE_BITS > VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int XW = (AW > INDEX_W) ? AW : INDEX_W;

    logic [KEY_W-1:0]      r_mask;
    logic [KW-1:0]         key_w;
    logic [KW-1:0]         mask_w;
    logic [VW-1:0]         val_in_w;
    logic [VW-1:0]         val_out_w;
    logic [XW-1:0]         idx_out_w;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         key_raddr;
    logic [AW-1:0]         val_raddr;
    logic [KEY_BITS-1:0]   key_rdata;
    logic [VALUE_BITS-1:0] val_rdata;
    logic [AW-1:0]         res_index;
    logic [VALUE_BITS-1:0] res_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '1;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_wdata;
        end
    end

    assign key_w    = KW'(i_key);
    assign mask_w   = KW'(r_mask);
    assign val_in_w = VW'(i_value);

    aokvt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (KEY_BITS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (key_w[KEY_BITS-1:0]),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    aokvt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VALUE_BITS)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (val_in_w[VALUE_BITS-1:0]),
        .i_raddr (val_raddr),
        .o_rdata (val_rdata)
    );

    aokvt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_key         (key_w[KEY_BITS-1:0]),
        .i_entry_index (i_entry_index),
        .i_mask        (mask_w[KEY_BITS-1:0]),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_key_raddr   (key_raddr),
        .o_val_raddr   (val_raddr),
        .i_key_rdata   (key_rdata),
        .i_val_rdata   (val_rdata),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_status      (o_status),
        .o_index       (res_index),
        .o_value       (res_value)
    );

    assign idx_out_w     = XW'(res_index);
    assign val_out_w     = VW'(res_value);
    assign o_found_index = idx_out_w[INDEX_W-1:0];
    assign o_read_value  = val_out_w[VALUE_W-1:0];

endmodule

// File: tb/append_only_key_value_table_checker.sv
// Checker for the key/value table: predicts each answer from accepted requests and compares.
module append_only_key_value_table_checker
    import aokvt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [KEY_W-1:0]   i_cfg_wdata,
    input  logic               i_req_valid,
    input  logic               i_req_stall,
    input  t_opcode            i_opcode,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [INDEX_W-1:0] i_entry_index,
    input  logic               i_rsp_valid,
    input  logic               i_rsp_stall,
    input  t_status            i_status,
    input  logic [INDEX_W-1:0] i_found_index,
    input  logic [VALUE_W-1:0] i_read_value,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status             status;
        logic [INDEX_W-1:0]  found_index;
        logic [VALUE_W-1:0]  read_value;
    } t_table_answer;

    logic [KEY_W-1:0]   stored_keys   [TABLE_DEPTH];
    logic [VALUE_W-1:0] stored_values [TABLE_DEPTH];
    int unsigned        stored_count;
    logic [KEY_W-1:0]   compare_mask;
    t_table_answer      answers_due [$];

    function automatic t_table_answer predict_answer(input t_opcode op,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [VALUE_W-1:0] value,
                                                     input logic [INDEX_W-1:0] index);
        t_table_answer ans;
        ans = '0;
        case (op)
            OP_APPEND: begin
                if (stored_count >= TABLE_DEPTH) begin
                    ans.status = STS_FULL;
                end else begin
                    stored_keys[stored_count]   = key;
                    stored_values[stored_count] = value;
                    ans.found_index = INDEX_W'(stored_count);
                    stored_count++;
                end
            end
            OP_FIND: begin
                ans.status = STS_NOT_FOUND;
                for (int unsigned i = 0; i < stored_count; i++) begin
                    if (((stored_keys[i] ^ key) & compare_mask) == '0) begin
                        ans.status      = STS_OK;
                        ans.found_index = INDEX_W'(i);
                        break;
                    end
                end
            end
            default: begin
                if (index < stored_count) begin
                    ans.read_value = stored_values[index];
                end else begin
                    ans.status = STS_UNWRITTEN;
                end
            end
        endcase
        return ans;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (o_fail_count < 10) begin
            $display("tb: mismatch on result %0d: %s expected %0h, got %0h",
                     o_checked, field, want, got);
        end
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_table_answer want;
        if (!i_rst_n) begin
            stored_count = 0;
            compare_mask = '1;
            answers_due.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_cfg_we) begin
                compare_mask = i_cfg_wdata;
            end
            if (i_req_valid && !i_req_stall) begin
                answers_due.push_back(predict_answer(i_opcode, i_key, i_value, i_entry_index));
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                o_checked++;
                if (answers_due.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("tb: unexpected result %0d: status %0h index %0h value %0h",
                                 o_checked, i_status, i_found_index, i_read_value);
                    end
                    o_fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (i_status !== want.status) begin
                        note_mismatch("status", want.status, i_status);
                    end
                    if (i_found_index !== want.found_index) begin
                        note_mismatch("found_index", want.found_index, i_found_index);
                    end
                    if (i_read_value !== want.read_value) begin
                        note_mismatch("read_value", want.read_value, i_read_value);
                    end
                end
            end
        end
        o_pending = answers_due.size();
    end

endmodule

// File: tb/append_only_key_value_table_tb.sv
// Testbench top: drives requests and mask writes into the key/value table and gives the verdict.
module append_only_key_value_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import aokvt_pkg::*;

    localparam int      TABLE_DEPTH     = DEF_TABLE_DEPTH;
    localparam int      ITEMS_PER_PHASE = 88;
    localparam int      NUM_PHASES      = 6;
    localparam int      TAIL_ITEMS      = 30;
    localparam t_opcode OP_UNUSED       = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [KEY_W-1:0]   i_cfg_wdata;
    logic               i_valid;
    logic               o_stall;
    t_opcode            i_opcode;
    logic [KEY_W-1:0]   i_key;
    logic [VALUE_W-1:0] i_value;
    logic [INDEX_W-1:0] i_entry_index;
    logic               o_valid;
    logic               i_stall;
    t_status            o_status;
    logic [INDEX_W-1:0] o_found_index;
    logic [VALUE_W-1:0] o_read_value;

    int fail_count;
    int pending_count;
    int checked_count;

    int               send_idle_pct;
    int               recv_stall_pct;
    logic [KEY_W-1:0] cur_mask;
    logic [KEY_W-1:0] appended_keys [$];
    int               op_counts [4];
    int               mask_writes;

    append_only_key_value_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (DEF_KEY_BITS),
        .VALUE_BITS  (DEF_VALUE_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_entry_index (i_entry_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_read_value  (o_read_value)
    );

    append_only_key_value_table_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_entry_index (i_entry_index),
        .i_rsp_valid   (o_valid),
        .i_rsp_stall   (i_stall),
        .i_status      (o_status),
        .i_found_index (o_found_index),
        .i_read_value  (o_read_value),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count),
        .o_checked     (checked_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("tb: failure");
        $finish;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_item(input t_opcode op, input logic [KEY_W-1:0] key,
                             input logic [VALUE_W-1:0] value,
                             input logic [INDEX_W-1:0] index);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_key         <= key;
        i_value       <= value;
        i_entry_index <= index;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        op_counts[op]++;
        if (op == OP_APPEND && appended_keys.size() < TABLE_DEPTH) begin
            appended_keys.push_back(key);
        end
    endtask

    // Drop valid and wait for every answer before touching the mask.
    task automatic write_mask(input logic [KEY_W-1:0] mask);
        i_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mask;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mask = mask;
        mask_writes++;
    endtask

    task automatic issue_random_item();
        int unsigned        pick;
        t_opcode            op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        pick  = $urandom_range(99);
        key   = $urandom;
        value = $urandom;
        index = INDEX_W'($urandom);
        if ($urandom_range(19) == 0) begin
            key = ($urandom_range(1) != 0) ? '0 : '1;
        end
        if (pick < 36) begin
            op = OP_APPEND;
            if (appended_keys.size() != 0 && $urandom_range(4) == 0) begin
                key = appended_keys[$urandom_range(appended_keys.size() - 1)];
            end
        end else if (pick < 70) begin
            op = OP_FIND;
            if (appended_keys.size() != 0 && $urandom_range(9) < 7) begin
                key = appended_keys[$urandom_range(appended_keys.size() - 1)];
                if ($urandom_range(1) != 0) begin
                    key = key ^ ($urandom & ~cur_mask);
                end
            end
        end else if (pick < 94) begin
            op = OP_READ;
            if (appended_keys.size() != 0 && $urandom_range(4) != 0) begin
                index = INDEX_W'($urandom_range(appended_keys.size() - 1));
            end
        end else begin
            op = OP_UNUSED;
        end
        send_item(op, key, value, index);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct  = 27;
                recv_stall_pct = 62;
            end
            1: begin
                send_idle_pct  = 62;
                recv_stall_pct = 27;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    initial begin
        logic [KEY_W-1:0] phase_mask;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_valid       = 1'b0;
        i_opcode      = OP_APPEND;
        i_key         = '0;
        i_value       = '0;
        i_entry_index = '0;
        i_stall       = 1'b0;
        cur_mask      = '1;
        mask_writes   = 0;
        for (int i = 0; i < 4; i++) op_counts[i] = 0;
        set_idling(0);
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(OP_FIND,   32'h0000_0000, 32'hFFFF_FFFF, 10'h3FF);
        send_item(OP_READ,   32'hFFFF_FFFF, 32'h0000_0000, 10'h000);
        send_item(OP_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF, 10'h3FF);
        send_item(OP_APPEND, 32'h0000_0000, 32'h0000_0000, 10'h3FF);
        send_item(OP_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h000);
        send_item(OP_APPEND, 32'h1234_5678, 32'hA5A5_A5A5, 10'h155);
        send_item(OP_APPEND, 32'h0000_0000, 32'h0000_0001, 10'h2AA);
        send_item(OP_FIND,   32'h0000_0000, 32'h5A5A_5A5A, 10'h155);
        send_item(OP_FIND,   32'hFFFF_FFFF, 32'h0000_0000, 10'h2AA);
        send_item(OP_FIND,   32'h1234_5679, 32'h0000_0000, 10'h000);
        send_item(OP_READ,   32'h0000_0000, 32'h0000_0000, 10'h001);
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'h0000_0000, 10'h003);
        send_item(OP_READ,   32'h0000_0000, 32'hFFFF_FFFF, 10'h004);
        send_item(OP_READ,   32'h0000_0000, 32'h0000_0000, 10'h3FF);
        send_item(OP_READ,   32'h0000_0000, 32'h0000_0000, 10'h000);
        write_mask(32'hFFFF_FF00);
        send_item(OP_FIND,   32'h1234_56FF, 32'h0000_0000, 10'h000);
        send_item(OP_FIND,   32'h0000_00AB, 32'h0000_0000, 10'h000);
        write_mask(32'h0000_0000);
        send_item(OP_FIND,   $urandom, $urandom, INDEX_W'($urandom));

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       phase_mask = 32'hFFFF_FFFF;
                2:       phase_mask = 32'h0000_0000;
                3:       phase_mask = 32'h0000_00FF;
                5:       phase_mask = 32'hFFFF_FFFF;
                default: phase_mask = $urandom;
            endcase
            write_mask(phase_mask);
            set_idling(phase / 2);
            repeat (ITEMS_PER_PHASE) issue_random_item();
        end

        // Probe the newest entry and the last index.
        write_mask(32'hFFFF_FFFF);
        set_idling(2);
        send_item(OP_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
        send_item(OP_READ,   32'h0000_0000, 32'h0000_0000, 10'h3FF);
        send_item(OP_FIND,   appended_keys[appended_keys.size() - 1], 32'h0000_0000,
                  10'h000);
        send_item(OP_FIND,   $urandom, $urandom, INDEX_W'($urandom));
        write_mask($urandom);
        repeat (TAIL_ITEMS) issue_random_item();

        i_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("tb: sent %0d appends, %0d finds, %0d reads and %0d reads on the spare opcode",
                 op_counts[OP_APPEND], op_counts[OP_FIND], op_counts[OP_READ],
                 op_counts[OP_UNUSED]);
        $display("tb: %0d answers checked under %0d mask settings, table filled to %0d entries",
                 checked_count, mask_writes, appended_keys.size());
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
